// ----- rtl/core/b2a_pkg.sv -----
package b2a_pkg;

  // Selector codes carried on the input tuser
  localparam logic [1:0] FUNC_DEC     = 2'd0;
  localparam logic [1:0] FUNC_HEX     = 2'd1;
  localparam logic [1:0] FUNC_PTR     = 2'd2;
  localparam logic [1:0] FUNC_PTR_ALT = 2'd3;

  // ASCII codes
  localparam logic [6:0] ASCII_ZERO     = 7'd48;  // '0'
  localparam logic [6:0] ASCII_X        = 7'd120; // 'x'
  localparam logic [6:0] ASCII_HEX_BASE = 7'd55;  // 'A' minus ten

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CONV = 6'b000010,
    ST_SKIP = 6'b000100,
    ST_PFX0 = 6'b001000,
    ST_PFXX = 6'b010000,
    ST_DIG  = 6'b100000
  } state_e;

  // One BCD or hex digit to its ASCII character
  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = ASCII_ZERO + 7'(d);
    end else begin
      c = ASCII_HEX_BASE + 7'(d);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/b2a_dabble.sv -----
module b2a_dabble #(
  parameter int NDIG = 20
) (
  input  logic [NDIG*4-1:0] bcd_i,
  input  logic              bit_i,
  output logic [NDIG*4-1:0] bcd_o
);
  import b2a_pkg::*;

  logic [NDIG*4-1:0] adj;

  // Add three to every digit of five or more, all digits side by side
  for (genvar g = 0; g < NDIG; g++) begin : g_digit
    assign adj[g*4 +: 4] = (bcd_i[g*4 +: 4] >= 4'd5) ? (bcd_i[g*4 +: 4] + 4'd3)
                                                     : bcd_i[g*4 +: 4];
  end

  // Shift in the next binary bit
  assign bcd_o = {adj[NDIG*4-2:0], bit_i};

endmodule

// ----- rtl/core/binary_to_ascii_digits_core.sv -----
// Binary to ASCII digit converter.
// Input beat: s_axis_tdata_i carries the unsigned value (low VALUE_WIDTH
// bits used), s_axis_tuser_i the format: decimal, uppercase hex, or hex
// behind a "0x" prefix. Output: one ASCII character per beat, most
// significant first, leading zeros suppressed; tlast marks the last one.
// A zero value gives "0" (or "0x0" in pointer form).
// Timing: one item at a time; s_axis_tready_o is high only while idle.
// Decimal runs a shift-add-3 loop over all VALUE_WIDTH bits on one shared
// digit-adjust unit; hex loads the digits directly. Then each suppressed
// leading zero (at most NDIG-1) is shifted out in turn, the scan ends,
// pointer form sends two prefix beats, and each character takes one beat.
// Leading zeros and characters always add up to NDIG (20 at 64 bits).
// Reset returns the sequencer to idle and drops m_axis_tvalid_o.
// A stalled receiver holds the current character beat steady; the
// sequencer simply waits on m_axis_tready_i.
module binary_to_ascii_digits_core #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [63:0]              s_axis_tdata_i,  // [63:0] value
  input  logic [1:0]               s_axis_tuser_i,  // [1:0] func
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [7:0]               m_axis_tdata_o,  // [6:0] ascii_char, [7] zero
  output logic                     m_axis_tlast_o   // last
);
  import b2a_pkg::*;

  localparam int NDIG = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int DW   = NDIG * 4;
  localparam int CW   = $clog2(NDIG + 1);
  localparam int BW   = $clog2(VALUE_WIDTH + 1);

  state_e                 state_q, state_d;
  logic [DW-1:0]          dig_q, dig_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [BW-1:0]          bitcnt_q, bitcnt_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   ptr_q, ptr_d;
  logic [DW-1:0]          dab;
  logic [3:0]             top;
  logic                   in_fire;
  logic                   out_fire;
  logic                   is_last;
  logic [6:0]             out_char;

  // Shared digit adjust-and-shift unit
  b2a_dabble #(
    .NDIG(NDIG)
  ) u_dabble (
    .bcd_i(dig_q),
    .bit_i(val_q[VALUE_WIDTH-1]),
    .bcd_o(dab)
  );

  assign top       = dig_q[DW-1 -: 4];
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire  = m_axis_tvalid_o && m_axis_tready_i;
  assign is_last   = (state_q == ST_DIG) && (cnt_q == CW'(1));

  // Handshake outputs
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_PFX0) || (state_q == ST_PFXX) ||
                           (state_q == ST_DIG);
  assign m_axis_tdata_o  = {1'b0, out_char};
  assign m_axis_tlast_o  = is_last;

  // Character mux
  always_comb begin
    unique case (state_q)
      ST_PFX0: out_char = ASCII_ZERO;
      ST_PFXX: out_char = ASCII_X;
      default: out_char = digit_char(top);
    endcase
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    dig_d    = dig_q;
    val_d    = val_q;
    bitcnt_d = bitcnt_q;
    cnt_d    = cnt_q;
    ptr_d    = ptr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          val_d    = s_axis_tdata_i[VALUE_WIDTH-1:0];
          bitcnt_d = BW'(VALUE_WIDTH);
          cnt_d    = CW'(NDIG);
          ptr_d    = (s_axis_tuser_i == FUNC_PTR) || (s_axis_tuser_i == FUNC_PTR_ALT);
          if (s_axis_tuser_i == FUNC_DEC) begin
            dig_d   = '0;
            state_d = ST_CONV;
          end else begin
            dig_d   = DW'(s_axis_tdata_i[VALUE_WIDTH-1:0]);
            state_d = ST_SKIP;
          end
        end
      end
      ST_CONV: begin
        dig_d    = dab;
        val_d    = {val_q[VALUE_WIDTH-2:0], 1'b0};
        bitcnt_d = bitcnt_q - BW'(1);
        if (bitcnt_q == BW'(1)) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keeping at least one digit
        if ((top == 4'd0) && (cnt_q != CW'(1))) begin
          dig_d = {dig_q[DW-5:0], 4'h0};
          cnt_d = cnt_q - CW'(1);
        end else if (ptr_q) begin
          state_d = ST_PFX0;
        end else begin
          state_d = ST_DIG;
        end
      end
      ST_PFX0: begin
        if (out_fire) begin
          state_d = ST_PFXX;
        end
      end
      ST_PFXX: begin
        if (out_fire) begin
          state_d = ST_DIG;
        end
      end
      ST_DIG: begin
        if (out_fire) begin
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            dig_d = {dig_q[DW-5:0], 4'h0};
            cnt_d = cnt_q - CW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    dig_q    <= dig_d;
    val_q    <= val_d;
    bitcnt_q <= bitcnt_d;
    cnt_q    <= cnt_d;
    ptr_q    <= ptr_d;
  end

endmodule
